@@ rtl/mat_pkg.sv @@
// shared constants, types and exponential table generation for the metropolis acceptance test
package mat_pkg;

    localparam int COST_W     = 32;
    localparam int RAND_W     = 31;
    localparam int INV_TEMP_W = 48;
    localparam int PROD_LO_W  = 64;
    localparam int PROD_HI_W  = 48;
    localparam int TOP_W      = 49;
    localparam int SLICE_W    = 10;
    localparam int FRAC_W     = 3 * SLICE_W;
    localparam int ROM_DEPTH  = 1 << SLICE_W;
    localparam int ROM_W      = 32;
    localparam int PROB_W     = 32;
    localparam int ABC_W      = 63;
    localparam int STAGES     = 8;

    // reject when the scaled exponent passes 80
    localparam logic [TOP_W-1:0] REJECT_TOP  = TOP_W'(80);
    // x < 0.0001 exactly when p < ceil(2^32 / 10000)
    localparam logic [31:0]      LINEAR_LIM  = 32'd429497;
    localparam logic [PROB_W-1:0] ONE_Q31    = 32'h8000_0000;
    localparam logic [ABC_W-1:0] HALF_Q31    = ABC_W'(64'h4000_0000);

    typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] t_rom;

    // restoring division, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-2^-sh) in q62 from a truncated alternating series
    function automatic logic [63:0] exp_neg_pow2(input int sh);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'h4000_0000_0000_0000;
        sum  = 64'h4000_0000_0000_0000;
        for (int k = 1; k <= 24; k++) begin
            term = udiv64(term >> sh, 64'(k));
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // running q62 power, rounded to q31 per entry
    function automatic t_rom build_rom(input int sh);
        t_rom        rom;
        logic [63:0] base;
        logic [63:0] v;
        logic [127:0] prod;
        logic [63:0] rv;
        base   = exp_neg_pow2(sh);
        v      = 64'h4000_0000_0000_0000;
        rom[0] = 32'h8000_0000;
        for (int i = 1; i < ROM_DEPTH; i++) begin
            prod   = {64'd0, v} * {64'd0, base};
            v      = prod[125:62];
            rv     = v + 64'h4000_0000;
            rom[i] = rv[62:31];
        end
        return rom;
    endfunction

    localparam t_rom ROM_A = build_rom(3);
    localparam t_rom ROM_B = build_rom(13);
    localparam t_rom ROM_C = build_rom(23);

endpackage

@@ rtl/metropolis_accept_test.sv @@
// top level of the metropolis acceptance test
// Usage:
//   s_axis carries one proposed move per transfer: tdata[31:0] is the signed
//   cost change, tdata[62:32] the 31-bit random value (bit 63 is zero).
//   m_axis returns one decision per move: tdata[0] is 1 to accept, 0 to reject.
//   i_cfg_wr_en / i_cfg_wr_data write the 48-bit reciprocal temperature
//   (2^32 / T); write it only while no move is in flight. Zero accepts all.
// Latency and throughput:
//   eight register stages from input transfer to a valid result: operand
//   capture, the split 32x32 / 32x16 product, the carry merge, the three
//   registered table reads, a multiply stage, a rounding stage and a second
//   multiply stage; the last stage rounds and compares with the random value.
//   One move is taken every cycle when the output is not stalled.
// Reset and stalls:
//   reset clears all stage valid bits and the reciprocal temperature. When
//   the receiver holds m_axis_tready low with a result waiting, the whole
//   pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
module metropolis_accept_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [mat_pkg::INV_TEMP_W-1:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // cost_change [31:0], random_value [62:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // accept [0]
);
    import mat_pkg::*;

    logic [INV_TEMP_W-1:0] r_inv_temp;
    logic [STAGES-1:0]     r_valid;
    logic                  w_adv;

    // stage 1
    logic                 r_s1_neg;
    logic [COST_W-1:0]    r_s1_mag;
    logic [RAND_W-1:0]    r_s1_rand;
    // stage 2
    logic                 r_s2_neg;
    logic [PROD_LO_W-1:0] r_s2_lo;
    logic [PROD_HI_W-1:0] r_s2_hi;
    logic [RAND_W-1:0]    r_s2_rand;
    // stage 3
    logic                 r_s3_neg;
    logic [TOP_W-1:0]     r_s3_top;
    logic [31:0]          r_s3_low;
    logic [RAND_W-1:0]    r_s3_rand;
    // stages 4 to 7 carry the decision flags alongside the table unit
    logic [3:0]           r_force_acc;
    logic [3:0]           r_force_rej;
    logic [3:0]           r_linear;
    logic [PROB_W-1:0]    r_lin_prob [4];
    logic [RAND_W-1:0]    r_rand     [4];
    // stage 8
    logic                 r_s8_acc;

    logic [COST_W-1:0]    n_s1_mag;
    logic [PROD_LO_W-1:0] n_s2_lo;
    logic [PROD_HI_W-1:0] n_s2_hi;
    logic [TOP_W-1:0]     n_s3_top;
    logic                 n_reject;
    logic                 n_linear;
    logic [32:0]          n_half;
    logic [PROB_W-1:0]    n_lin_prob;
    logic [FRAC_W-1:0]    n_frac;
    logic [ABC_W-1:0]     w_prod;
    logic [ABC_W-1:0]     n_prod_rnd;
    logic [PROB_W-1:0]    n_prob;
    logic                 n_s8_acc;

    assign w_adv         = !r_valid[STAGES-1] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_valid[STAGES-1];
    assign m_axis_tdata  = {7'd0, r_s8_acc};

    always_comb begin
        n_s1_mag = (~s_axis_tdata[COST_W-1:0]) + 32'd1;
        n_s2_lo  = {32'd0, r_s1_mag} * {32'd0, r_inv_temp[31:0]};
        n_s2_hi  = PROD_HI_W'({16'd0, r_s1_mag} * {32'd0, r_inv_temp[INV_TEMP_W-1:32]});
        n_s3_top = {1'b0, r_s2_hi} + TOP_W'(r_s2_lo[63:32]);
        n_reject = (r_s3_top > REJECT_TOP) ||
                   ((r_s3_top == REJECT_TOP) && (r_s3_low != 32'd0));
        n_linear = (r_s3_top == '0) && (r_s3_low < LINEAR_LIM);
        n_half   = ({1'b0, r_s3_low} + 33'd1) >> 1;
        n_lin_prob = ONE_Q31 - n_half[PROB_W-1:0];
        // floor(x * 2^23); top is at most 80 whenever the table is used
        n_frac   = {r_s3_top[6:0], r_s3_low[31:9]};
        n_prod_rnd = w_prod + HALF_Q31;
        n_prob   = r_linear[3] ? r_lin_prob[3] : n_prod_rnd[ABC_W-1 -: PROB_W];
        n_s8_acc = r_force_acc[3] ||
                   (!r_force_rej[3] && (n_prob > {1'b0, r_rand[3]}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_temp <= '0;
        end else if (i_cfg_wr_en) begin
            r_inv_temp <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_adv) begin
            r_valid <= {r_valid[STAGES-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_neg  <= s_axis_tdata[COST_W-1];
            r_s1_mag  <= n_s1_mag;
            r_s1_rand <= s_axis_tdata[62:32];

            r_s2_neg  <= r_s1_neg;
            r_s2_lo   <= n_s2_lo;
            r_s2_hi   <= n_s2_hi;
            r_s2_rand <= r_s1_rand;

            r_s3_neg  <= r_s2_neg;
            r_s3_top  <= n_s3_top;
            r_s3_low  <= r_s2_lo[31:0];
            r_s3_rand <= r_s2_rand;

            r_force_acc <= {r_force_acc[2:0], !r_s3_neg};
            r_force_rej <= {r_force_rej[2:0], r_s3_neg && n_reject};
            r_linear    <= {r_linear[2:0], n_linear};
            r_lin_prob[0] <= n_lin_prob;
            r_rand[0]     <= r_s3_rand;
            for (int i = 1; i < 4; i++) begin
                r_lin_prob[i] <= r_lin_prob[i-1];
                r_rand[i]     <= r_rand[i-1];
            end

            r_s8_acc <= n_s8_acc;
        end
    end

    mat_exp_table u_exp_table (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_frac (n_frac),
        .o_prod (w_prod)
    );

    // a move that does not raise the cost leaves as an accept
    a_force_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[6] && r_force_acc[3] && w_adv |=> m_axis_tdata[0])
        else $error("forced accept lost");

    // an exponent past the limit leaves as a reject
    a_force_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[6] && r_force_rej[3] && w_adv |=> !m_axis_tdata[0])
        else $error("forced reject lost");

    // the linear region never overlaps the reject region
    a_lin_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[3] && r_linear[0] |-> !r_force_rej[0])
        else $error("linear and reject both set");

endmodule

@@ rtl/mat_exp_table.sv @@
// pipelined exp(-x) from three q31 tables, four register stages
module mat_exp_table (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [mat_pkg::FRAC_W-1:0]  i_frac,
    output logic [mat_pkg::ABC_W-1:0]   o_prod
);
    import mat_pkg::*;

    logic [ROM_W-1:0]  r_a;
    logic [ROM_W-1:0]  r_b;
    logic [ROM_W-1:0]  r_c;
    logic [ABC_W-1:0]  r_ab;
    logic [ROM_W-1:0]  r_c5;
    logic [PROB_W-1:0] r_abr;
    logic [ROM_W-1:0]  r_c6;
    logic [ABC_W-1:0]  r_prod;

    logic [ABC_W-1:0]  n_ab;
    logic [ABC_W-1:0]  n_ab_rnd;
    logic [ABC_W-1:0]  n_prod;

    always_comb begin
        n_ab     = ABC_W'({32'd0, r_a} * {32'd0, r_b});
        n_ab_rnd = r_ab + HALF_Q31;
        n_prod   = ABC_W'({32'd0, r_abr} * {32'd0, r_c6});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // table reads, registered
            r_a    <= ROM_A[i_frac[FRAC_W-1 -: SLICE_W]];
            r_b    <= ROM_B[i_frac[2*SLICE_W-1 -: SLICE_W]];
            r_c    <= ROM_C[i_frac[SLICE_W-1:0]];
            r_ab   <= n_ab;
            r_c5   <= r_c;
            r_abr  <= n_ab_rnd[ABC_W-1 -: PROB_W];
            r_c6   <= r_c5;
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

@@ bench/tb.sv @@
// self-checking bench for the metropolis acceptance test: directed corners, then random moves
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_CYCLES  = 500000;
    localparam int          ITEMS_PER_T = 150;
    localparam int          SETTLE      = 12;
    localparam logic [47:0] INV_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] INV_UNIT_T  = 48'h0001_0000_0000;
    localparam logic [31:0] PROB_ONE    = 32'h8000_0000;
    localparam logic [63:0] ROUND_HALF  = 64'h4000_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [mat_pkg::INV_TEMP_W-1:0] i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // cost_change [31:0], random_value [62:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // accept [0]

    logic [mat_pkg::INV_TEMP_W-1:0] inv_temp_model;
    logic [31:0] exp_rom [3][1024];
    logic        pending_decisions [$];
    logic        wanted_accept;
    int          error_count;
    int          cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    metropolis_accept_test dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // exp(-2^-sh) in q62 from the alternating series, then running powers rounded to q31
    task automatic fill_exp_rom(input int which, input int sh);
        logic [63:0] term;
        logic [63:0] base;
        logic [63:0] power;
        logic [127:0] wide;
        term = 64'h4000_0000_0000_0000;
        base = 64'h4000_0000_0000_0000;
        for (int k = 1; k <= 24; k++) begin
            term = (term >> sh) / 64'(k);
            if (k % 2 == 1) begin
                base = base - term;
            end else begin
                base = base + term;
            end
        end
        power = 64'h4000_0000_0000_0000;
        exp_rom[which][0] = PROB_ONE;
        for (int i = 1; i < 1024; i++) begin
            wide  = 128'(power) * 128'(base);
            power = wide[125:62];
            exp_rom[which][i] = 32'((power + ROUND_HALF) >> 31);
        end
    endtask

    // acceptance probability in q31; a non-raising move gives one, a hopeless one zero
    function automatic logic [31:0] move_prob(input logic [31:0] cost, input logic [47:0] inv);
        logic [32:0] mag;
        logic [80:0] prod;
        logic [29:0] frac;
        logic [63:0] acc;
        if (!cost[31]) return PROB_ONE;
        mag  = 33'h1_0000_0000 - {1'b0, cost};
        prod = 81'(mag) * 81'(inv);
        if (prod > (81'd80 << 32)) return 32'd0;
        if (prod * 81'd10000 < 81'h1_0000_0000) return PROB_ONE - 32'((prod + 81'd1) >> 1);
        frac = prod[38:9];
        acc  = 64'(exp_rom[0][frac[29:20]]) * 64'(exp_rom[1][frac[19:10]]);
        acc  = (acc + ROUND_HALF) >> 31;
        acc  = acc * 64'(exp_rom[2][frac[9:0]]);
        acc  = (acc + ROUND_HALF) >> 31;
        return acc[31:0];
    endfunction

    // half uniform, half right at the decision threshold
    function automatic logic [30:0] pick_random_value(input logic [31:0] cost);
        longint v;
        if ($urandom_range(1) == 0) return 31'($urandom);
        v = longint'(move_prob(cost, inv_temp_model)) + longint'($urandom_range(4)) - 2;
        if (v < 0) v = 0;
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        return 31'(v);
    endfunction

    // mostly negative changes aimed at a scaled exponent within the interesting range
    function automatic logic [31:0] pick_cost();
        int unsigned kind;
        logic [63:0] target;
        logic [63:0] mag;
        kind = $urandom_range(99);
        if (kind < 15) return {1'b0, 31'($urandom)};
        if (kind < 30) return 32'($urandom);
        target = {$urandom, $urandom} >> $urandom_range(63, 25);
        if (inv_temp_model == '0) begin
            mag = (64'($urandom) & 64'h7FFF_FFFF) + 64'd1;
        end else begin
            mag = target / 64'(inv_temp_model);
        end
        if (mag == 64'd0) mag = 64'd1;
        if (mag > 64'h8000_0000) mag = (64'($urandom) & 64'h7FFF_FFFF) + 64'd1;
        return 32'(64'h1_0000_0000 - mag);
    endfunction

    function automatic logic [47:0] pick_inv_temp();
        return 48'({$urandom, $urandom} >> $urandom_range(63, 16));
    endfunction

    // entered and left at a falling edge
    task automatic send_move(input logic [31:0] cost, input logic [30:0] rnd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, rnd, cost};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_decisions.push_back(move_prob(cost, inv_temp_model) > {1'b0, rnd});
        @(negedge i_clk);
    endtask

    task automatic send_probe(input logic [31:0] cost);
        send_move(cost, pick_random_value(cost));
    endtask

    task automatic drain_decisions();
        s_axis_tvalid = 1'b0;
        while (pending_decisions.size() != 0) @(negedge i_clk);
    endtask

    // the register only changes with the pipeline empty
    task automatic write_inv_temp(input logic [47:0] value);
        drain_decisions();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en    = 1'b0;
        inv_temp_model = value;
    endtask

    task automatic test_zero_temperature();
        // register still at its reset value: everything goes
        send_move(32'h8000_0000, 31'h7FFF_FFFF);
        send_move(32'hFFFF_FFFF, 31'h0);
        send_move(32'h8000_0001, 31'h7FFF_FFFF);
    endtask

    task automatic test_non_negative();
        write_inv_temp(INV_MAX);
        send_move(32'h0000_0000, 31'h7FFF_FFFF);
        send_move(32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_move(32'h0000_0001, 31'($urandom));
    endtask

    task automatic test_reject_limit();
        // unit temperature: the exponent equals the cost magnitude
        write_inv_temp(INV_UNIT_T);
        send_probe(-32'sd80);
        send_probe(-32'sd81);
        write_inv_temp(INV_UNIT_T + 48'd1);
        send_probe(-32'sd80);
        write_inv_temp(INV_MAX);
        send_move(32'h8000_0000, 31'h0);
    endtask

    task automatic test_linear_region();
        write_inv_temp(48'd1);
        send_probe(-32'sd1);
        send_move(-32'sd1, 31'h0);
        send_probe(-32'sd429496);
        send_probe(-32'sd429497);
        send_probe(32'h8000_0000);
    endtask

    task automatic test_table_lookup();
        write_inv_temp(48'h0000_0123_4567);
        repeat (6) send_probe(pick_cost());
    endtask

    task automatic test_random_moves();
        int seg;
        int unsigned idle_sched [4] = '{0, 50, 0, 14};
        int unsigned stall_sched [4] = '{0, 0, 50, 14};
        for (int ph = 0; ph < 4; ph++) begin
            for (int t = 0; t < 3; t++) begin
                seg = ph * 3 + t;
                if (seg == 0) begin
                    write_inv_temp('0);
                end else if (seg == 1) begin
                    write_inv_temp(INV_MAX);
                end else begin
                    write_inv_temp(pick_inv_temp());
                end
                send_idle_pct  = idle_sched[ph];
                recv_stall_pct = stall_sched[ph];
                repeat (ITEMS_PER_T) send_probe(pick_cost());
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_decisions.size() == 0) begin
                $error("accept: no decision pending, got %0b", m_axis_tdata[0]);
                error_count++;
            end else begin
                wanted_accept = pending_decisions.pop_front();
                if (m_axis_tdata[0] !== wanted_accept) begin
                    $error("accept: expected %0b, got %0b", wanted_accept, m_axis_tdata[0]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("metropolis_accept_test verification failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        inv_temp_model = '0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fill_exp_rom(0, 3);
        fill_exp_rom(1, 13);
        fill_exp_rom(2, 23);
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_zero_temperature();
        test_non_negative();
        test_reject_limit();
        test_linear_region();
        test_table_lookup();
        test_random_moves();

        drain_decisions();
        repeat (SETTLE * 2) @(posedge i_clk);
        if (error_count == 0) begin
            $display("metropolis_accept_test verification clean");
        end else begin
            $display("metropolis_accept_test verification failed");
        end
        $finish;
    end
endmodule
